### src/cmf_pkg.sv
// shared types and constants for the cross median filter
package cmf_pkg;

	localparam int MAX_LINE_WIDTH = 256;
	localparam int PIXEL_BITS     = 8;
	localparam int DIM_W          = 9;
	localparam int LINE_AW        = $clog2(MAX_LINE_WIDTH);
	localparam int CFG_IDX_W      = 1;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DIM_W-1:0] MIN_DIM  = DIM_W'(3);
	localparam logic [DIM_W-1:0] MAX_WID  = DIM_W'(MAX_LINE_WIDTH);
	localparam logic [DIM_W-1:0] ROW_SAT  = {DIM_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = CFG_IDX_W'(1);

	typedef logic signed [PIXEL_BITS-1:0] pix_t;

	localparam pix_t PIX_MAX = pix_t'((1 << (PIXEL_BITS - 1)) - 1);

	typedef struct packed {
		pix_t pixel_value;
		logic start_of_frame;
	} sample_t;

	typedef struct packed {
		pix_t median_value;
		logic last_of_frame;
	} result_t;

	// the five values of one cross plus the frame end mark
	typedef struct packed {
		pix_t north;
		pix_t south;
		pix_t west;
		pix_t center;
		pix_t east;
		logic last;
	} cross_t;

	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_entry_t;

endpackage

### src/cross_median_filter_top.sv
// top level of the five-point cross median filter
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------
//  pixels   | push / full         | sample: pixel_value, start_of_frame
//  results  | pop / empty         | result: median_value, last_of_frame
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data (9 bits)
//
// one pixel per clock while full is low; the line store port (one read, one write
// a cycle) sets that; a cross passes the stage-one registers and the middle queue
// and its result the result queue; front, median and result queue stall apart;
// full rises once the middle queue cannot take what is still in flight
// reset clears counters, queues and window; line stores stay unknown until written
module cross_median_filter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  cmf_pkg::sample_t                sample,
	output logic                            empty,
	input  logic                            pop,
	output cmf_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cmf_pkg::DIM_W-1:0]       cfg_data
);
	import cmf_pkg::*;

	logic               q_push, q_pop, q_empty;
	cross_t             q_wdata, q_rdata;
	logic [QLVL_W-1:0]  q_level;

	cmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.q_level   (q_level),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	cmf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.level  (q_level)
	);

	cmf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

### src/cmf_front.sv
// front end: config, position tracking, line stores, window and interior classification
module cmf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cmf_pkg::DIM_W-1:0]       cfg_data,
	input  logic                            push,
	output logic                            full,
	input  cmf_pkg::sample_t                sample,
	input  logic [cmf_pkg::QLVL_W-1:0]      q_level,
	output logic                            q_push,
	output cmf_pkg::cross_t                 q_data
);
	import cmf_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] col_q, row_q;
	logic [DIM_W-1:0] c_cur, r_cur, c_inc, row_inc, cfg_w, cfg_h;
	logic             accept, wrap_in;

	logic                 v_s1, int_s1, last_s1, byp_s1;
	logic [LINE_AW-1:0]   addr_s1;
	pix_t                 pix_s1;
	line_entry_t          rd_s1;
	line_entry_t          wr_q;
	line_entry_t          cur, wr_entry;
	pix_t                 north_q, south_q, west_q, center_q;

	line_entry_t line_mem [MAX_LINE_WIDTH];

	assign cfg_ready = 1'b1;

	always_comb begin
		cfg_w = cfg_data;
		if (cfg_data < MIN_DIM) begin
			cfg_w = MIN_DIM;
		end else if (cfg_data > MAX_WID) begin
			cfg_w = MAX_WID;
		end
		cfg_h = (cfg_data < MIN_DIM) ? MIN_DIM : cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MAX_WID;
			height_q <= MAX_WID;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ACTIVE_WIDTH:  width_q  <= cfg_w;
				REG_ACTIVE_HEIGHT: height_q <= cfg_h;
				default: ;
			endcase
		end
	end

	assign accept = push & ~full;
	assign full   = (q_level + QLVL_W'(v_s1 & int_s1)) >= QLVL_W'(QUEUE_DEPTH);

	// position of this pixel, then of the next one
	always_comb begin
		wrap_in = col_q >= width_q;
		row_inc = (row_q == ROW_SAT) ? row_q : row_q + DIM_W'(1);
		if (sample.start_of_frame) begin
			c_cur = '0;
			r_cur = '0;
		end else if (wrap_in) begin
			c_cur = '0;
			r_cur = row_inc;
		end else begin
			c_cur = col_q;
			r_cur = row_q;
		end
		c_inc = c_cur + DIM_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c_inc >= width_q) begin
				col_q <= '0;
				row_q <= (r_cur == ROW_SAT) ? r_cur : r_cur + DIM_W'(1);
			end else begin
				col_q <= c_inc;
				row_q <= r_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			int_s1  <= 1'b0;
			last_s1 <= 1'b0;
			byp_s1  <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				int_s1  <= (r_cur >= DIM_W'(2)) && (r_cur < height_q) && (c_cur >= DIM_W'(2));
				last_s1 <= (r_cur == height_q - DIM_W'(1)) && (c_cur == width_q - DIM_W'(1));
				// entry being written this cycle is the one read: forward it
				byp_s1  <= v_s1 && (addr_s1 == c_cur[LINE_AW-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= c_cur[LINE_AW-1:0];
			pix_s1  <= sample.pixel_value;
			rd_s1   <= line_mem[c_cur[LINE_AW-1:0]];
		end
		if (v_s1) begin
			line_mem[addr_s1] <= wr_entry;
		end
	end

	always_comb begin
		cur             = byp_s1 ? wr_q : rd_s1;
		wr_entry.upper  = cur.middle;
		wr_entry.middle = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			north_q  <= '0;
			south_q  <= '0;
			west_q   <= '0;
			center_q <= '0;
		end else if (v_s1) begin
			north_q  <= cur.upper;
			south_q  <= pix_s1;
			west_q   <= center_q;
			center_q <= cur.middle;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			wr_q <= wr_entry;
		end
	end

	assign q_push        = v_s1 & int_s1;
	assign q_data.north  = north_q;
	assign q_data.south  = south_q;
	assign q_data.west   = west_q;
	assign q_data.center = center_q;
	assign q_data.east   = cur.middle;
	assign q_data.last   = last_s1;

endmodule

### src/cmf_queue.sv
// short queue of classified crosses between front and back
module cmf_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  cmf_pkg::cross_t             wdata,
	input  logic                        pop,
	output cmf_pkg::cross_t             rdata,
	output logic                        empty,
	output logic [cmf_pkg::QLVL_W-1:0]  level
);
	import cmf_pkg::*;

	cross_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QLVL_W-1:0]   count_q;
	logic                do_pop;

	assign empty  = (count_q == '0);
	assign level  = count_q;
	assign rdata  = entries_q[rd_ptr_q];
	assign do_pop = pop & ~empty;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QLVL_W'(push) - QLVL_W'(do_pop);
		end
	end

endmodule

### src/cmf_back.sv
// back end: five-value median and the result queue
module cmf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  cmf_pkg::cross_t     q_data,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output cmf_pkg::result_t    result
);
	import cmf_pkg::*;

	localparam int OUT_DEPTH = 2;

	result_t      res_q [OUT_DEPTH];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         out_pop, space;
	result_t      res_new;

	// third smallest, kept as a sorted list of the three lowest
	function automatic pix_t median5(input cross_t x);
		pix_t v [5];
		pix_t lo0, lo1, lo2;
		v[0] = x.north;
		v[1] = x.south;
		v[2] = x.west;
		v[3] = x.east;
		v[4] = x.center;
		lo0  = PIX_MAX;
		lo1  = PIX_MAX;
		lo2  = PIX_MAX;
		for (int i = 0; i < 5; i++) begin
			if (v[i] <= lo0) begin
				lo2 = lo1;
				lo1 = lo0;
				lo0 = v[i];
			end else if (v[i] <= lo1) begin
				lo2 = lo1;
				lo1 = v[i];
			end else if (v[i] <= lo2) begin
				lo2 = v[i];
			end
		end
		return lo2;
	endfunction

	assign out_pop = pop & ~empty;
	assign empty   = (cnt_q == 2'd0);
	assign space   = (cnt_q != 2'(OUT_DEPTH)) | out_pop;
	assign q_pop   = ~q_empty & space;
	assign result  = res_q[rp_q];

	always_comb begin
		res_new.median_value  = median5(q_data);
		res_new.last_of_frame = q_data.last;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q[wp_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (q_pop) begin
				wp_q <= ~wp_q;
			end
			if (out_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(q_pop) - 2'(out_pop);
		end
	end

endmodule
